FILE: sv/newton_integer_sqrt_unit_macros.svh
`ifndef NEWTON_INTEGER_SQRT_UNIT_MACROS_SVH
`define NEWTON_INTEGER_SQRT_UNIT_MACROS_SVH

// antecedent at one edge, consequent a fixed number of cycles later
`define NISQ_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##dly (cons)) else $error("nisq check failed");

// consequent now needs the antecedent a fixed number of cycles back
`define NISQ_ASSERT_BACK(label, clk, rst_n, cons, ante, dly) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cons) |-> $past((ante), dly)) else $error("nisq check failed");

`endif

FILE: sv/nisq_pkg.sv
`timescale 1ns / 1ps

package nisq_pkg;

  localparam int DW       = 32;
  localparam int RW       = 16;
  localparam int DIV_BITS = DW;

  localparam logic [DW-1:0] SEED_LIMIT_LOW  = 32'd4194304;
  localparam logic [DW-1:0] SEED_LIMIT_MID  = 32'd134217728;
  localparam int            SEED_SHIFT_LOW  = 10;
  localparam int            SEED_SHIFT_MID  = 12;
  localparam int            SEED_SHIFT_HIGH = 14;
  localparam logic [DW-1:0] SEED_BIAS_LOW   = 32'd63;
  localparam logic [DW-1:0] SEED_BIAS_MID   = 32'd255;
  localparam logic [DW-1:0] SEED_BIAS_HIGH  = 32'd1023;

  typedef struct packed {
    logic          zero;
    logic [DW-1:0] x;
    logic [DW-1:0] r;
  } step_t;

  typedef struct packed {
    logic          zero;
    logic [DW-1:0] x;
    logic [DW-1:0] r;
    logic [DW-1:0] rem;
    logic [DW-1:0] qn;
  } cell_t;

endpackage

FILE: sv/nisq_seed.sv
`timescale 1ns / 1ps

module nisq_seed (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_in,
  input  logic [nisq_pkg::DW-1:0]    x_in,
  output logic                       valid_out,
  output nisq_pkg::step_t            data_out
);

  logic            valid_r;
  nisq_pkg::step_t data_r;
  nisq_pkg::step_t data_nxt;

  always_comb begin
    data_nxt.zero = (x_in == '0);
    data_nxt.x    = x_in;
    if (x_in <= nisq_pkg::SEED_LIMIT_LOW) begin
      data_nxt.r = (x_in >> nisq_pkg::SEED_SHIFT_LOW) + nisq_pkg::SEED_BIAS_LOW;
    end else if (x_in <= nisq_pkg::SEED_LIMIT_MID) begin
      data_nxt.r = (x_in >> nisq_pkg::SEED_SHIFT_MID) + nisq_pkg::SEED_BIAS_MID;
    end else begin
      data_nxt.r = (x_in >> nisq_pkg::SEED_SHIFT_HIGH) + nisq_pkg::SEED_BIAS_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

FILE: sv/nisq_div_cell.sv
`timescale 1ns / 1ps

module nisq_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  nisq_pkg::cell_t data_in,
  output logic            valid_out,
  output nisq_pkg::cell_t data_out
);

  logic                   valid_r;
  nisq_pkg::cell_t        data_r;
  nisq_pkg::cell_t        data_nxt;
  logic [nisq_pkg::DW:0]  rem_sh;
  logic [nisq_pkg::DW:0]  diff;
  logic                   ge;

  // one restoring step: bring down the next dividend bit, try the divisor
  always_comb begin
    rem_sh        = {data_in.rem, data_in.qn[nisq_pkg::DW-1]};
    diff          = rem_sh - {1'b0, data_in.r};
    ge            = (rem_sh >= {1'b0, data_in.r});
    data_nxt      = data_in;
    data_nxt.rem  = ge ? diff[nisq_pkg::DW-1:0] : rem_sh[nisq_pkg::DW-1:0];
    data_nxt.qn   = {data_in.qn[nisq_pkg::DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

FILE: sv/nisq_step.sv
`timescale 1ns / 1ps

module nisq_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  nisq_pkg::step_t data_in,
  output logic            valid_out,
  output nisq_pkg::step_t data_out
);

  nisq_pkg::cell_t       chain [0:nisq_pkg::DIV_BITS];
  logic                  chain_v [0:nisq_pkg::DIV_BITS];
  logic                  valid_r;
  nisq_pkg::step_t       data_r;
  nisq_pkg::step_t       data_nxt;
  logic [nisq_pkg::DW:0] sum;

  always_comb begin
    chain[0].zero = data_in.zero;
    chain[0].x    = data_in.x;
    chain[0].r    = data_in.r;
    chain[0].rem  = '0;
    chain[0].qn   = data_in.x;
    chain_v[0]    = valid_in;
  end

  genvar g;
  generate
    for (g = 0; g < nisq_pkg::DIV_BITS; g++) begin : g_cell
      nisq_div_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (chain_v[g]),
        .data_in   (chain[g]),
        .valid_out (chain_v[g+1]),
        .data_out  (chain[g+1])
      );
    end
  endgenerate

  // r <- (r + x / r) >> 1
  always_comb begin
    sum           = {1'b0, chain[nisq_pkg::DIV_BITS].r} + {1'b0, chain[nisq_pkg::DIV_BITS].qn};
    data_nxt.zero = chain[nisq_pkg::DIV_BITS].zero;
    data_nxt.x    = chain[nisq_pkg::DIV_BITS].x;
    data_nxt.r    = sum[nisq_pkg::DW:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= chain_v[nisq_pkg::DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

FILE: sv/newton_integer_sqrt_unit.sv
`timescale 1ns / 1ps

// Integer square root by seeded Newton iteration, fully pipelined.
// Input: drive in_radicand and raise start; the transaction is taken at a
// rising edge with start high and busy low. busy is high while reset is
// applied and until the first rising edge after it is released; otherwise it
// is low, so a new transaction can enter every cycle.
// Output: out_root is shown for exactly one cycle with out_valid high, once
// the transaction has passed the seed register, every Newton step and the
// output register. Results come out in the order radicands went in.
// Each Newton step is a row of 32 division cells, one quotient bit per cell,
// followed by one averaging stage; the seed and the output each add a stage.
// Throughput is one transaction per cycle while busy is low.
// Reset (synchronous, active low) empties the pipeline; transactions in
// flight are dropped. The receiver cannot stall the output, and the block
// keeps no state between transactions.
module newton_integer_sqrt_unit #(
  parameter int NEWTON_STEPS = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [nisq_pkg::DW-1:0] in_radicand,
  output logic                    out_valid,
  output logic [nisq_pkg::RW-1:0] out_root
);

  nisq_pkg::step_t         stage   [0:NEWTON_STEPS];
  logic                    stage_v [0:NEWTON_STEPS];
  logic                    busy_r;
  logic                    out_valid_r;
  logic [nisq_pkg::RW-1:0] out_root_r;
  logic [nisq_pkg::RW-1:0] out_root_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  nisq_seed u_seed (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (start && !busy_r),
    .x_in      (in_radicand),
    .valid_out (stage_v[0]),
    .data_out  (stage[0])
  );

  genvar g;
  generate
    for (g = 0; g < NEWTON_STEPS; g++) begin : g_step
      nisq_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (stage_v[g]),
        .data_in   (stage[g]),
        .valid_out (stage_v[g+1]),
        .data_out  (stage[g+1])
      );
    end
  endgenerate

  assign out_root_nxt = stage[NEWTON_STEPS].zero ? '0 :
                        stage[NEWTON_STEPS].r[nisq_pkg::RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stage_v[NEWTON_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    out_root_r <= out_root_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

endmodule

FILE: sv/nisq_checker.sv
`timescale 1ns / 1ps
`include "newton_integer_sqrt_unit_macros.svh"

module nisq_checker #(
  parameter int NEWTON_STEPS = 5
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [nisq_pkg::DW-1:0] in_radicand,
  input logic                    out_valid,
  input logic [nisq_pkg::RW-1:0] out_root
);

  localparam int LAT = 2 + (nisq_pkg::DIV_BITS + 1) * NEWTON_STEPS;

  `NISQ_ASSERT_AFTER(a_result_follows, clk, rst_n, start && !busy, LAT, out_valid)
  `NISQ_ASSERT_BACK(a_no_spurious, clk, rst_n, out_valid, start && !busy, LAT)
  `NISQ_ASSERT_AFTER(a_zero_root, clk, rst_n, start && !busy && in_radicand == '0, LAT, out_root == '0)

endmodule

bind newton_integer_sqrt_unit nisq_checker #(
  .NEWTON_STEPS (NEWTON_STEPS)
) u_nisq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_radicand (in_radicand),
  .out_valid   (out_valid),
  .out_root    (out_root)
);
